>>> design/ifps_pkg.sv
// Shared types and constants for the image field point sampler.
// No dependencies; every other design file imports this package.
package ifps_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int MAX_DIM     = 256;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = IDX_W + 1;
   localparam int DATA_W      = 32;
   localparam int REQ_DATA_W  = ADDR_W + 4 * DATA_W;
   localparam int CSR_IDX_W   = 3;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_FIELD_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_VALUE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_SCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_SCALE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS    = 3'd7;

   localparam logic [DATA_W-1:0] SCALE_ONE = 32'h0001_0000;

   typedef enum logic [1:0] {
      VIEW_XY,
      VIEW_ZX,
      VIEW_YZ
   } view_type;

   typedef enum logic [1:0] {
      EXT_ERROR,
      EXT_BOUNDARY,
      EXT_DEFAULT
   } ext_type;

   typedef struct packed {
      view_type          view;
      ext_type           ext;
      logic [DATA_W-1:0] dflt_value;
      logic [DATA_W-1:0] col_offset;
      logic [DATA_W-1:0] col_scale;
      logic [DATA_W-1:0] row_base;
      logic [DATA_W-1:0] row_gain;
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  rows;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic wr_en;
      logic mul_en;
      logic clamp_en;
      logic addr_en;
      logic rd_en;
      logic out_load;
   } cmd_type;

endpackage

>>> design/ifps_regs.sv
// Configuration registers with mode decode and image size saturation.
// Depends on ifps_pkg.
module ifps_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ifps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ifps_pkg::DATA_W-1:0]    csr_data,
   output ifps_pkg::cfg_type              cfg
);
   import ifps_pkg::*;

   logic [3:0]        field_mode_ff;
   logic [DATA_W-1:0] dflt_value_ff;
   logic [DATA_W-1:0] col_offset_ff;
   logic [DATA_W-1:0] col_scale_ff;
   logic [DATA_W-1:0] row_base_ff;
   logic [DATA_W-1:0] row_gain_ff;
   logic [DIM_W-1:0]  image_cols_ff;
   logic [DIM_W-1:0]  image_rows_ff;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff    <= '0;
         dflt_value_ff    <= '0;
         col_offset_ff    <= '0;
         col_scale_ff     <= SCALE_ONE;
         row_base_ff      <= '0;
         row_gain_ff      <= SCALE_ONE;
         image_cols_ff    <= DIM_W'(1);
         image_rows_ff    <= DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FIELD_MODE:    field_mode_ff    <= csr_data[3:0];
            REG_DEFAULT_VALUE: dflt_value_ff    <= csr_data;
            REG_COLUMN_OFFSET: col_offset_ff    <= csr_data;
            REG_COLUMN_SCALE:  col_scale_ff     <= csr_data;
            REG_ROW_OFFSET:    row_base_ff      <= csr_data;
            REG_ROW_SCALE:     row_gain_ff      <= csr_data;
            REG_IMAGE_COLS:    image_cols_ff    <= csr_data[DIM_W-1:0];
            REG_IMAGE_ROWS:    image_rows_ff    <= csr_data[DIM_W-1:0];
            default:           ;
         endcase
      end
   end

   // mode = view*3 + exterior; codes above 8 act as 8
   always_comb begin
      case (field_mode_ff)
         4'd0: begin cfg.view = VIEW_XY; cfg.ext = EXT_ERROR;    end
         4'd1: begin cfg.view = VIEW_XY; cfg.ext = EXT_BOUNDARY; end
         4'd2: begin cfg.view = VIEW_XY; cfg.ext = EXT_DEFAULT;  end
         4'd3: begin cfg.view = VIEW_ZX; cfg.ext = EXT_ERROR;    end
         4'd4: begin cfg.view = VIEW_ZX; cfg.ext = EXT_BOUNDARY; end
         4'd5: begin cfg.view = VIEW_ZX; cfg.ext = EXT_DEFAULT;  end
         4'd6: begin cfg.view = VIEW_YZ; cfg.ext = EXT_ERROR;    end
         4'd7: begin cfg.view = VIEW_YZ; cfg.ext = EXT_BOUNDARY; end
         default: begin cfg.view = VIEW_YZ; cfg.ext = EXT_DEFAULT; end
      endcase
      cfg.dflt_value    = dflt_value_ff;
      cfg.col_offset    = col_offset_ff;
      cfg.col_scale     = col_scale_ff;
      cfg.row_base      = row_base_ff;
      cfg.row_gain      = row_gain_ff;
      cfg.cols          = sat_dim(image_cols_ff);
      cfg.rows          = sat_dim(image_rows_ff);
   end

endmodule

>>> design/ifps_ctrl.sv
// Sequencing state machine: accepts beats, steps the datapath, owns rsp valid.
// Depends on ifps_pkg.
module ifps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ifps_pkg::cmd_type cmd
);
   import ifps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLAMP,
      ST_ADDR,
      ST_READ,
      ST_DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.capture  = accept && (req_tuser == REQ_QUERY);
      cmd.wr_en    = accept && (req_tuser == REQ_LOAD);
      cmd.mul_en   = (state_ff == ST_MUL);
      cmd.clamp_en = (state_ff == ST_CLAMP);
      cmd.addr_en  = (state_ff == ST_ADDR);
      cmd.rd_en    = (state_ff == ST_READ);
      cmd.out_load = (state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (cmd.capture) state_in = ST_MUL;
         ST_MUL:     state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_ADDR;
         ST_ADDR:    state_in = ST_READ;
         ST_READ:    state_in = ST_DELIVER;
         ST_DELIVER: if (cmd.out_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_query_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.capture))
      else $error("load and query taken in the same beat");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_MUL))
      else $error("accepted query did not start the sequence");

   a_read_then_deliver: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_DELIVER))
      else $error("table read not followed by delivery");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten before it was taken");

   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

>>> design/ifps_datapath.sv
// Index arithmetic, clamping, address forming, pixel table and result register.
// Depends on ifps_pkg; stepped by ifps_ctrl commands.
module ifps_datapath (
   input  logic                            clock,
   input  ifps_pkg::cfg_type               cfg,
   input  ifps_pkg::cmd_type               cmd,
   input  logic [ifps_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [ifps_pkg::DATA_W-1:0]     field_value,
   output logic                            was_outside,
   output logic                            range_error
);
   import ifps_pkg::*;

   logic [ADDR_W-1:0] pixel_index;
   logic [DATA_W-1:0] pixel_value, coord_x, coord_y, coord_z;
   logic [DATA_W-1:0] c_coord, r_coord;

   logic [DATA_W:0]   d_col_ff, d_row_ff, d_col_in, d_row_in;
   logic [DATA_W-1:0] hi_col_ff, hi_row_ff;
   logic [2*DATA_W-1:0] prod_col, prod_row;
   logic              neg_col_ff, neg_row_ff, zero_col_ff, zero_row_ff;
   logic [IDX_W:0]    cl_col, cl_row;
   logic [IDX_W-1:0]  ci_ff, ri_ff;
   logic              outside_ff;
   logic [DIM_W-1:0]  flip;
   logic [2*DIM_W-1:0] addr_wide;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] rd_ff;
   logic [DATA_W-1:0] field_value_ff;
   logic              was_outside_ff, range_error_ff;

   logic [DATA_W-1:0] pixel_table [TABLE_DEPTH];

   // {outside, index}
   function automatic logic [IDX_W:0] clamp_idx(input logic zero, input logic neg,
                                                input logic [DATA_W-1:0] hi,
                                                input logic [DIM_W-1:0] size);
      logic [IDX_W:0] r;
      if (zero) begin
         r = '0;
      end else if (neg) begin
         r = {1'b1, {IDX_W{1'b0}}};
      end else if (hi >= DATA_W'(size)) begin
         r = {1'b1, IDX_W'(size - DIM_W'(1))};
      end else begin
         r = {1'b0, hi[IDX_W-1:0]};
      end
      return r;
   endfunction

   assign pixel_index = req_tdata[ADDR_W-1:0];
   assign pixel_value = req_tdata[ADDR_W +: DATA_W];
   assign coord_x     = req_tdata[ADDR_W + DATA_W +: DATA_W];
   assign coord_y     = req_tdata[ADDR_W + 2*DATA_W +: DATA_W];
   assign coord_z     = req_tdata[ADDR_W + 3*DATA_W +: DATA_W];

   always_comb begin
      case (cfg.view)
         VIEW_XY: begin c_coord = coord_x; r_coord = coord_y; end
         VIEW_ZX: begin c_coord = coord_z; r_coord = coord_x; end
         default: begin c_coord = coord_y; r_coord = coord_z; end
      endcase
      d_col_in = {c_coord[DATA_W-1], c_coord} - {cfg.col_offset[DATA_W-1], cfg.col_offset};
      d_row_in = {r_coord[DATA_W-1], r_coord} - {cfg.row_base[DATA_W-1], cfg.row_base};
   end

   assign prod_col  = d_col_ff[DATA_W-1:0] * cfg.col_scale;
   assign prod_row  = d_row_ff[DATA_W-1:0] * cfg.row_gain;
   assign cl_col    = clamp_idx(zero_col_ff, neg_col_ff, hi_col_ff, cfg.cols);
   assign cl_row    = clamp_idx(zero_row_ff, neg_row_ff, hi_row_ff, cfg.rows);
   // rows stored top first
   assign flip      = cfg.rows - DIM_W'(1) - DIM_W'(ri_ff);
   assign addr_wide = flip * cfg.cols + (2*DIM_W)'(ci_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         d_col_ff <= d_col_in;
         d_row_ff <= d_row_in;
      end
      if (cmd.mul_en) begin
         hi_col_ff   <= prod_col[2*DATA_W-1:DATA_W];
         hi_row_ff   <= prod_row[2*DATA_W-1:DATA_W];
         neg_col_ff  <= d_col_ff[DATA_W];
         neg_row_ff  <= d_row_ff[DATA_W];
         zero_col_ff <= (cfg.col_scale == '0);
         zero_row_ff <= (cfg.row_gain == '0);
      end
      if (cmd.clamp_en) begin
         ci_ff      <= cl_col[IDX_W-1:0];
         ri_ff      <= cl_row[IDX_W-1:0];
         outside_ff <= cl_col[IDX_W] | cl_row[IDX_W];
      end
      if (cmd.addr_en) begin
         addr_ff <= addr_wide[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         pixel_table[pixel_index] <= pixel_value;
      end
      if (cmd.rd_en) begin
         rd_ff <= pixel_table[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         was_outside_ff <= outside_ff;
         if (!outside_ff || cfg.ext == EXT_BOUNDARY) begin
            field_value_ff <= rd_ff;
            range_error_ff <= 1'b0;
         end else if (cfg.ext == EXT_DEFAULT) begin
            field_value_ff <= cfg.dflt_value;
            range_error_ff <= 1'b0;
         end else begin
            field_value_ff <= '0;
            range_error_ff <= 1'b1;
         end
      end
   end

   assign field_value = field_value_ff;
   assign was_outside = was_outside_ff;
   assign range_error = range_error_ff;

endmodule

>>> design/image_field_point_sampler_top.sv
// Nearest-neighbour sampler of a Q16.16 scalar field held as an image. A load beat
// (tuser 0) writes one pixel into the 64K-word table in its accepting cycle and gives
// no response. A query beat (tuser 1) gives one response after the controller has stepped
// through the registered 32x32 scale multiplies, the clamp, the row-address multiply and
// the registered table read; a new beat is taken only once that result sits in the output
// register, so queries do not overlap. Loads run at one per cycle while no query is in
// progress. The table is not cleared at reset: a query that lands on a pixel never loaded
// returns an undefined value.
// Configuration writes are always accepted and are meant for idle periods only.
// Depends on ifps_pkg, ifps_regs, ifps_ctrl and ifps_datapath.
module image_field_point_sampler_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pixel_index[15:0], pixel_value[47:16], coord_x[79:48], coord_y[111:80],
   // coord_z[143:112]
   input  logic [ifps_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // field_value[31:0]
   output logic [ifps_pkg::DATA_W-1:0]     rsp_tdata,
   // was_outside[0], range_error[1]
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ifps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ifps_pkg::DATA_W-1:0]     csr_data
);
   import ifps_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    was_outside, range_error;

   ifps_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ifps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ifps_datapath u_datapath (
      .clock       (clock),
      .cfg         (cfg),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .field_value (rsp_tdata),
      .was_outside (was_outside),
      .range_error (range_error)
   );

   assign rsp_tuser = {range_error, was_outside};

endmodule

>>> tb/image_field_point_sampler_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for image_field_point_sampler_top: loads and point queries go in,
// sampled values are predicted in-bench and compared beat by beat at the response port.
// Depends on ifps_pkg and the design files under design/.
module image_field_point_sampler_top_test;
   import ifps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 15;
   localparam int PHASE_BEATS = 90;

   typedef struct {
      logic [3:0]  mode;
      logic [31:0] dflt;
      logic [31:0] col_off;
      logic [31:0] col_scale;
      logic [31:0] row_off;
      logic [31:0] row_gain;
      logic [8:0]  cols;
      logic [8:0]  rows;
   } field_regs_type;

   typedef struct {
      logic        kind;
      logic [15:0] index;
      logic [31:0] value;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } beat_type;

   typedef struct {
      logic [31:0] value;
      logic        outside;
      logic        err;
   } sample_type;

   typedef struct {
      logic [15:0] addr;
      logic        outside;
   } spot_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]      csr_data = '0;

   field_regs_type field_regs;
   logic [31:0] pixel_mem [0:TABLE_DEPTH-1];
   bit          loaded [0:TABLE_DEPTH-1];
   beat_type    beats_to_send[$];
   sample_type  predicted_samples[$];
   beat_type    req_beat;
   logic        req_fired = 1'b0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          idle_span = 7;
   bit          quiet = 1'b0;
   int          queued = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   image_field_point_sampler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [8:0] sat_dim(input logic [8:0] dim);
      if (dim == 9'd0) return 9'd1;
      if (dim > 9'(MAX_DIM)) return 9'(MAX_DIM);
      return dim;
   endfunction

   function automatic void decode_mode(output view_type view, output ext_type ext);
      logic [3:0] m;
      m = (field_regs.mode > 4'd8) ? 4'd8 : field_regs.mode;
      view = view_type'(2'(m / 4'd3));
      ext = ext_type'(2'(m % 4'd3));
   endfunction

   // pixel index along one axis, clamped; scale of zero pins it to 0
   function automatic logic [8:0] axis_index(input logic [31:0] coord, offset, scale,
                                             input logic [8:0] size, inout bit outside);
      longint      delta;
      logic [63:0] prod;
      delta = longint'($signed(coord)) - longint'($signed(offset));
      if (scale == '0) return 9'd0;
      if (delta < 0) begin
         outside = 1'b1;
         return 9'd0;
      end
      prod = 64'(delta) * {32'd0, scale};
      if (prod[63:32] >= {23'd0, size}) begin
         outside = 1'b1;
         return size - 9'd1;
      end
      return prod[40:32];
   endfunction

   function automatic spot_type spot_of(input logic [31:0] x, y, z);
      view_type    view;
      ext_type     ext;
      logic [31:0] cc;
      logic [31:0] rc;
      logic [8:0]  cols;
      logic [8:0]  rows;
      logic [8:0]  ci;
      logic [8:0]  ri;
      bit          out_flag;
      int          addr;
      spot_type    s;
      decode_mode(view, ext);
      cols = sat_dim(field_regs.cols);
      rows = sat_dim(field_regs.rows);
      case (view)
         VIEW_XY: begin
            cc = x;
            rc = y;
         end
         VIEW_ZX: begin
            cc = z;
            rc = x;
         end
         default: begin
            cc = y;
            rc = z;
         end
      endcase
      out_flag = 1'b0;
      ci = axis_index(cc, field_regs.col_off, field_regs.col_scale, cols, out_flag);
      ri = axis_index(rc, field_regs.row_off, field_regs.row_gain, rows, out_flag);
      // top row first in the table
      addr = int'(ci) + (int'(rows) - 1 - int'(ri)) * int'(cols);
      s.addr = addr[15:0];
      s.outside = out_flag;
      return s;
   endfunction

   function automatic sample_type sample_field(input beat_type b);
      view_type   view;
      ext_type    ext;
      spot_type   s;
      sample_type r;
      decode_mode(view, ext);
      s = spot_of(b.x, b.y, b.z);
      r.outside = s.outside;
      r.err = 1'b0;
      r.value = '0;
      if (!s.outside || ext == EXT_BOUNDARY) begin
         r.value = pixel_mem[s.addr];
      end else if (ext == EXT_DEFAULT) begin
         r.value = field_regs.dflt;
      end else begin
         r.err = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return SCALE_ONE;
         1: return 32'h0000_4000;
         2: return 32'h0004_0000;
         3: return 32'h0000_0000;
         4: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_offset();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return {{11{r[20]}}, r[20:0]};
      endcase
   endfunction

   function automatic logic [8:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 9'd256;
         1: return 9'd1;
         2: return 9'd0;
         3: return 9'h1ff;
         default: return 9'($urandom_range(1, 24));
      endcase
   endfunction

   // mostly lands around the image, with a margin either side
   function automatic logic [31:0] random_coord(input logic [31:0] offset, scale,
                                                input logic [8:0] size);
      logic [63:0] span;
      logic [63:0] width;
      logic [63:0] rnd;
      longint      pos;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return offset - 32'd1;
         default: begin
            if (scale == '0) return $urandom;
            span = ({55'd0, size} << 32) / {32'd0, scale};
            if (span > 64'h4_0000_0000) span = 64'h4_0000_0000;
            width = span + span / 2 + 64'd1;
            rnd = {$urandom, $urandom};
            pos = longint'($signed(offset)) - longint'(span / 4) + longint'(rnd % width);
            return pos[31:0];
         end
      endcase
   endfunction

   task automatic push_load(input logic [15:0] idx, input logic [31:0] value);
      beat_type b;
      loaded[idx] = 1'b1;
      b.kind = REQ_LOAD;
      b.index = idx;
      b.value = value;
      b.x = $urandom;
      b.y = $urandom;
      b.z = $urandom;
      beats_to_send = {beats_to_send, b};
      queued++;
   endtask

   // pixel under the point is loaded first if it never was
   task automatic push_query(input logic [31:0] x, y, z);
      spot_type s;
      beat_type b;
      s = spot_of(x, y, z);
      if (!loaded[s.addr]) push_load(s.addr, $urandom);
      b.kind = REQ_QUERY;
      b.index = $urandom;
      b.value = $urandom;
      b.x = x;
      b.y = y;
      b.z = z;
      beats_to_send = {beats_to_send, b};
      queued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FIELD_MODE:    field_regs.mode = data[3:0];
         REG_DEFAULT_VALUE: field_regs.dflt = data;
         REG_COLUMN_OFFSET: field_regs.col_off = data;
         REG_COLUMN_SCALE:  field_regs.col_scale = data;
         REG_ROW_OFFSET:    field_regs.row_off = data;
         REG_ROW_SCALE:     field_regs.row_gain = data;
         REG_IMAGE_COLS:    field_regs.cols = data[8:0];
         default:           field_regs.rows = data[8:0];
      endcase
   endtask

   // driver: beats and response stalls change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fired) begin
            if (req_gap != 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, idle_span) == 0) begin
               req_gap = $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
               req_beat = beats_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {req_beat.z, req_beat.y, req_beat.x, req_beat.value, req_beat.index};
               req_tuser <= req_beat.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, idle_span) == 0) begin
            rsp_gap = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: accepted beats update the table copy or queue a prediction
   always @(posedge clock) begin
      sample_type exp_s;
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (!reset && req_tvalid && req_tready) begin
            if (req_beat.kind == REQ_LOAD) begin
               pixel_mem[req_beat.index] = req_beat.value;
            end else begin
               predicted_samples = {predicted_samples, sample_field(req_beat)};
            end
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (predicted_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: value %h outside %b error %b",
                           rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
            end else begin
               exp_s = predicted_samples.pop_front();
               if (rsp_tdata !== exp_s.value || rsp_tuser[0] !== exp_s.outside ||
                   rsp_tuser[1] !== exp_s.err) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: value %h/%h outside %b/%b error %b/%b (exp/got)",
                              exp_s.value, rsp_tdata, exp_s.outside, rsp_tuser[0],
                              exp_s.err, rsp_tuser[1]);
               end
            end
         end
      end
   end

   initial begin
      int          p;
      int          phase_start;
      view_type    view;
      ext_type     ext;
      logic [8:0]  cols;
      logic [8:0]  rows;
      logic [31:0] cc;
      logic [31:0] rc;
      logic [31:0] free;
      logic [15:0] idx;
      logic [3:0]  mode;
      logic [31:0] dflt;
      logic [31:0] col_off;
      logic [31:0] col_scale;
      logic [31:0] row_off;
      logic [31:0] row_gain;
      logic [8:0]  col_dim;
      logic [8:0]  row_dim;

      field_regs.mode = 4'd0;
      field_regs.dflt = '0;
      field_regs.col_off = '0;
      field_regs.col_scale = SCALE_ONE;
      field_regs.row_off = '0;
      field_regs.row_gain = SCALE_ONE;
      field_regs.cols = 9'd1;
      field_regs.rows = 9'd1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            if (p <= 9) mode = 4'(p - 1);
            else if (p == 10) mode = 4'd15;
            else if (p == 11) mode = 4'd9;
            else mode = 4'($urandom_range(0, 15));
            case (p)
               1: begin
                  dflt = 32'h7fff_ffff;
                  col_off = '0;
                  col_scale = SCALE_ONE;
                  row_off = '0;
                  row_gain = SCALE_ONE;
                  col_dim = 9'd4;
                  row_dim = 9'd3;
               end
               2: begin
                  dflt = 32'h8000_0000;
                  col_off = 32'hff80_0000;
                  col_scale = SCALE_ONE;
                  row_off = 32'hff80_0000;
                  row_gain = SCALE_ONE;
                  col_dim = 9'd256;
                  row_dim = 9'd256;
               end
               3: begin
                  dflt = $urandom;
                  col_off = 32'h8000_0000;
                  col_scale = 32'hffff_ffff;
                  row_off = 32'h7fff_ffff;
                  row_gain = 32'h0000_0000;
                  col_dim = 9'd0;
                  row_dim = 9'h1ff;
               end
               4: begin
                  dflt = '0;
                  col_off = 32'h7fff_ffff;
                  col_scale = 32'h0000_0000;
                  row_off = 32'h8000_0000;
                  row_gain = 32'hffff_ffff;
                  col_dim = 9'd300;
                  row_dim = 9'd1;
               end
               default: begin
                  dflt = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : $urandom;
                  col_off = pick_offset();
                  col_scale = pick_scale();
                  row_off = pick_offset();
                  row_gain = pick_scale();
                  col_dim = pick_dim();
                  row_dim = pick_dim();
               end
            endcase
            write_reg(REG_FIELD_MODE, {28'd0, mode});
            write_reg(REG_DEFAULT_VALUE, dflt);
            write_reg(REG_COLUMN_OFFSET, col_off);
            write_reg(REG_COLUMN_SCALE, col_scale);
            write_reg(REG_ROW_OFFSET, row_off);
            write_reg(REG_ROW_SCALE, row_gain);
            write_reg(REG_IMAGE_COLS, {23'd0, col_dim});
            write_reg(REG_IMAGE_ROWS, {23'd0, row_dim});
            @(negedge clock);
            csr_valid <= 1'b0;
         end

         quiet = (p == PHASES - 1);
         idle_span = (p % 3 == 2) ? 40 : 7;
         phase_start = queued;

         // corners: most negative, most positive, left edge and just left of it
         if (p < 6) begin
            push_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            push_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
            push_query(field_regs.col_off, field_regs.col_off, field_regs.col_off);
            cc = field_regs.col_off - 32'd1;
            push_query(cc, cc, cc);
         end

         decode_mode(view, ext);
         cols = sat_dim(field_regs.cols);
         rows = sat_dim(field_regs.rows);
         while (queued - phase_start < PHASE_BEATS) begin
            if ($urandom_range(0, 9) < 7) begin
               cc = random_coord(field_regs.col_off, field_regs.col_scale, cols);
               rc = random_coord(field_regs.row_off, field_regs.row_gain, rows);
               free = $urandom;
               case (view)
                  VIEW_XY: push_query(cc, rc, free);
                  VIEW_ZX: push_query(rc, free, cc);
                  default: push_query(free, cc, rc);
               endcase
            end else begin
               if ($urandom_range(0, 1) == 0)
                  idx = 16'($urandom_range(0, int'(cols) * int'(rows) - 1));
               else
                  idx = 16'($urandom);
               push_load(idx, $urandom);
            end
         end

         while (beats_to_send.size() != 0 || req_tvalid || predicted_samples.size() != 0)
            @(posedge clock);
         repeat (8) @(posedge clock);
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_samples.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
